// File: rtl/asvdm_pkg.sv
// ----------------------------------------------------------------------------
// asvdm_pkg
// Shared widths, constants and control types of the sphere voxelizer.
// ----------------------------------------------------------------------------
package asvdm_pkg;

    localparam int CRD_W     = 20;  // coordinate field
    localparam int D_W       = 21;  // atom offset from origin
    localparam int SP_W      = 12;  // spacing, radius, probe
    localparam int R_W       = 13;  // atom radius plus probe
    localparam int RR_W      = 26;  // reach squared
    localparam int NUM_W     = 22;  // divider numerator magnitude
    localparam int OFF_W     = 23;  // voxel offset from centre
    localparam int SQ_W      = 46;  // offset squared
    localparam int ACC_W     = 48;  // squared distance sum
    localparam int DIST_W    = 16;
    localparam int CNT_W     = 16;
    localparam int DIMC_W    = 6;
    localparam int VIDX_W    = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 20;

    localparam int SQRT_STEPS = 13;
    localparam int SQRT_TOP   = 24;

    localparam logic [DIST_W-1:0] HUNDRED      = 16'd25600;
    localparam logic [DIST_W-1:0] TWO_HUNDRED  = 16'd51200;
    localparam logic [DIST_W-1:0] LOW_DIST_MAX = 16'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 4'd7;

    localparam logic [DIMC_W-1:0] DIM_RST     = 6'd32;
    localparam logic [SP_W-1:0]   SPACING_RST = 12'd128;
    localparam logic [SP_W-1:0]   PROBE_RST   = 12'd358;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       div_start;
        logic       div_capture;
        logic       bounds_init;
        logic       sq_en;
        logic [2:0] step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       merge;
        logic       advance;
        logic       out_load;
        logic       clr_en;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_read;
        logic div_busy;
        logic op_last;
        logic empty;
        logic in_sphere;
        logic last_voxel;
        logic clr_last;
    } t_dp_stat;

endpackage

// File: rtl/asvdm_ram.sv
// ----------------------------------------------------------------------------
// asvdm_ram
// Simple dual port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module asvdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/asvdm_div.sv
// ----------------------------------------------------------------------------
// asvdm_div
// Restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asvdm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [asvdm_pkg::NUM_W-1:0] i_num,
    input  logic [asvdm_pkg::SP_W-1:0]  i_den,
    output logic                       o_busy,
    output logic [asvdm_pkg::NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(asvdm_pkg::NUM_W + 1);

    logic [asvdm_pkg::SP_W-1:0]  r_rem;
    logic [asvdm_pkg::SP_W-1:0]  r_den;
    logic [asvdm_pkg::NUM_W-1:0] r_quo;
    logic [CW-1:0]               r_cnt;

    logic [asvdm_pkg::SP_W:0] w_sh;
    logic [asvdm_pkg::SP_W:0] w_sub;
    logic                     w_ge;

    assign w_sh  = {r_rem, r_quo[asvdm_pkg::NUM_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(asvdm_pkg::NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_sub[asvdm_pkg::SP_W-1:0] : w_sh[asvdm_pkg::SP_W-1:0];
            r_quo <= {r_quo[asvdm_pkg::NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;

endmodule

// File: rtl/asvdm_dp.sv
// ----------------------------------------------------------------------------
// asvdm_dp
// Datapath: config registers, bounds, voxel walk, distance math, stores.
// ----------------------------------------------------------------------------
module asvdm_dp #(
    parameter int GRID_MAX = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [asvdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [asvdm_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                            i_command,
    input  logic [asvdm_pkg::CRD_W-1:0]     i_atom_x,
    input  logic [asvdm_pkg::CRD_W-1:0]     i_atom_y,
    input  logic [asvdm_pkg::CRD_W-1:0]     i_atom_z,
    input  logic [asvdm_pkg::SP_W-1:0]      i_atom_radius,
    input  logic [asvdm_pkg::VIDX_W-1:0]    i_voxel_i,
    input  logic [asvdm_pkg::VIDX_W-1:0]    i_voxel_j,
    input  logic [asvdm_pkg::VIDX_W-1:0]    i_voxel_k,
    input  asvdm_pkg::t_dp_cmd              i_cmd,
    output asvdm_pkg::t_dp_stat             o_stat,
    output logic [asvdm_pkg::CNT_W-1:0]     o_voxels_inside,
    output logic [asvdm_pkg::DIST_W-1:0]    o_distance_value,
    output logic                            o_solvent_flag,
    output logic                            o_index_error
);

    localparam int IW    = $clog2(GRID_MAX);
    localparam int DMW   = $clog2(GRID_MAX + 1);
    localparam int DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);

    // config
    logic [asvdm_pkg::DIMC_W-1:0]  r_dim [3];
    logic [asvdm_pkg::SP_W-1:0]    r_spacing;
    logic [asvdm_pkg::SP_W-1:0]    r_probe;
    logic [asvdm_pkg::CRD_W-1:0]   r_org [3];

    // latched item
    logic                          r_cmd_read;
    logic [asvdm_pkg::VIDX_W-1:0]  r_vi, r_vj, r_vk;
    logic signed [asvdm_pkg::D_W-1:0] r_d [3];
    logic [asvdm_pkg::R_W-1:0]     r_r;
    logic [asvdm_pkg::RR_W-1:0]    r_rr;
    logic [asvdm_pkg::DIST_W-1:0]  r_thr;
    logic [asvdm_pkg::SP_W-1:0]    r_s;

    // bounds and walk
    logic [2:0]                    r_op;
    logic                          r_neg;
    logic [IW-1:0]                 r_lo [3];
    logic [IW-1:0]                 r_hi [3];
    logic [IW-1:0]                 r_idx [3];
    logic signed [asvdm_pkg::OFF_W-1:0] r_off;
    logic [asvdm_pkg::SQ_W-1:0]    r_prod;
    logic [asvdm_pkg::ACC_W-1:0]   r_acc;
    logic [asvdm_pkg::RR_W-1:0]    r_sv;
    logic [asvdm_pkg::RR_W-1:0]    r_root;
    logic [asvdm_pkg::RR_W-1:0]    r_bit;
    logic [asvdm_pkg::CNT_W-1:0]   r_count;
    logic [AW-1:0]                 r_clr_addr;

    logic [DMW-1:0] w_dim [3];
    logic [asvdm_pkg::DIST_W-1:0] w_rd_dist;
    logic                         w_rd_solv;

    function automatic logic [DMW-1:0] eff_dim(input logic [asvdm_pkg::DIMC_W-1:0] d);
        logic [DMW-1:0] v;
        if (d == '0) begin
            v = DMW'(1);
        end else if (32'(d) > GRID_MAX) begin
            v = DMW'(GRID_MAX);
        end else begin
            v = DMW'(d);
        end
        return v;
    endfunction

    function automatic logic [31:0] vox_addr(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a * GRID_MAX + b) * GRID_MAX + c;
    endfunction

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dim[a] = eff_dim(r_dim[a]);
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim[0]  <= asvdm_pkg::DIM_RST;
            r_dim[1]  <= asvdm_pkg::DIM_RST;
            r_dim[2]  <= asvdm_pkg::DIM_RST;
            r_spacing <= asvdm_pkg::SPACING_RST;
            r_probe   <= asvdm_pkg::PROBE_RST;
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                asvdm_pkg::CFG_DIM_X:    r_dim[0]  <= i_cfg_data[asvdm_pkg::DIMC_W-1:0];
                asvdm_pkg::CFG_DIM_Y:    r_dim[1]  <= i_cfg_data[asvdm_pkg::DIMC_W-1:0];
                asvdm_pkg::CFG_DIM_Z:    r_dim[2]  <= i_cfg_data[asvdm_pkg::DIMC_W-1:0];
                asvdm_pkg::CFG_SPACING:  r_spacing <= i_cfg_data[asvdm_pkg::SP_W-1:0];
                asvdm_pkg::CFG_PROBE:    r_probe   <= i_cfg_data[asvdm_pkg::SP_W-1:0];
                asvdm_pkg::CFG_ORIGIN_X: r_org[0]  <= i_cfg_data;
                asvdm_pkg::CFG_ORIGIN_Y: r_org[1]  <= i_cfg_data;
                asvdm_pkg::CFG_ORIGIN_Z: r_org[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divider operand: axis r_op[2:1], upper bound when r_op[0]
    logic signed [asvdm_pkg::D_W-1:0]   w_dsel;
    logic signed [asvdm_pkg::NUM_W-1:0] w_num;
    logic [asvdm_pkg::NUM_W-1:0]        w_mag;
    logic                               w_busy;
    logic [asvdm_pkg::NUM_W-1:0]        w_quot;

    always_comb begin
        unique case (r_op[2:1])
            2'd0:    w_dsel = r_d[0];
            2'd1:    w_dsel = r_d[1];
            default: w_dsel = r_d[2];
        endcase
        if (r_op[0]) begin
            w_num = asvdm_pkg::NUM_W'(w_dsel) + $signed({9'd0, r_r});
        end else begin
            w_num = asvdm_pkg::NUM_W'(w_dsel) - $signed({9'd0, r_r});
        end
        w_mag = w_num[asvdm_pkg::NUM_W-1] ? 22'(-w_num) : 22'(w_num);
    end

    asvdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_mag),
        .i_den   (r_s),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    // bound from quotient, truncated toward zero, then +-1 and clamped
    logic signed [asvdm_pkg::OFF_W-1:0] w_q;
    logic signed [asvdm_pkg::OFF_W:0]   w_b;
    logic [DMW-1:0]                     w_dmax;
    logic [IW-1:0]                      w_bound;

    always_comb begin
        unique case (r_op[2:1])
            2'd0:    w_dmax = w_dim[0] - 1'b1;
            2'd1:    w_dmax = w_dim[1] - 1'b1;
            default: w_dmax = w_dim[2] - 1'b1;
        endcase
        w_q = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        w_b = r_op[0] ? (24'(w_q) + 24'sd1) : (24'(w_q) - 24'sd1);
        if (w_b < 0) begin
            w_bound = '0;
        end else if (w_b > $signed({{(24 - DMW){1'b0}}, w_dmax})) begin
            w_bound = IW'(w_dmax);
        end else begin
            w_bound = IW'(w_b);
        end
    end

    // voxel offset for the axis of this step
    logic [IW-1:0]                      w_isel;
    logic signed [asvdm_pkg::D_W-1:0]   w_doff;
    logic [19:0]                        w_pos;
    logic signed [asvdm_pkg::OFF_W-1:0] w_off;
    logic signed [asvdm_pkg::SQ_W-1:0]  w_sqr;

    always_comb begin
        unique case (i_cmd.step)
            3'd0: begin
                w_isel = r_idx[0];
                w_doff = r_d[0];
            end
            3'd1: begin
                w_isel = r_idx[1];
                w_doff = r_d[1];
            end
            default: begin
                w_isel = r_idx[2];
                w_doff = r_d[2];
            end
        endcase
        w_pos = 20'(w_isel) * 20'(r_s);
        w_off = $signed({3'd0, w_pos}) - asvdm_pkg::OFF_W'(w_doff);
        w_sqr = r_off * r_off;
    end

    // square root step
    logic [asvdm_pkg::RR_W:0] w_trial;
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};

    // merge with stored distance
    logic [asvdm_pkg::DIST_W-1:0] w_value;
    logic [asvdm_pkg::DIST_W-1:0] w_nv;

    always_comb begin
        w_value = asvdm_pkg::HUNDRED - 16'(r_r) + 16'(r_root);
        if (w_rd_dist <= asvdm_pkg::LOW_DIST_MAX) begin
            w_nv = w_value;
        end else if (w_rd_dist < r_thr) begin
            w_nv = (w_value < w_rd_dist) ? w_value : w_rd_dist;
        end else if (w_value < r_thr) begin
            w_nv = w_value;
        end else begin
            w_nv = asvdm_pkg::TWO_HUNDRED;
        end
    end

    logic w_last_i, w_last_j, w_last_k;
    assign w_last_i = r_idx[0] == r_hi[0] - 1'b1;
    assign w_last_j = r_idx[1] == r_hi[1] - 1'b1;
    assign w_last_k = r_idx[2] == r_hi[2] - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_read <= i_command;
            r_vi       <= i_voxel_i;
            r_vj       <= i_voxel_j;
            r_vk       <= i_voxel_k;
            r_d[0]     <= $signed({i_atom_x[19], i_atom_x}) - $signed({r_org[0][19], r_org[0]});
            r_d[1]     <= $signed({i_atom_y[19], i_atom_y}) - $signed({r_org[1][19], r_org[1]});
            r_d[2]     <= $signed({i_atom_z[19], i_atom_z}) - $signed({r_org[2][19], r_org[2]});
            r_r        <= 13'(i_atom_radius) + 13'(r_probe);
            r_count    <= '0;
        end
        if (i_cmd.prep) begin
            r_rr  <= 26'(r_r) * 26'(r_r);
            r_thr <= asvdm_pkg::HUNDRED - 16'(r_probe);
            r_s   <= (r_spacing == '0) ? 12'd1 : r_spacing;
            r_op  <= '0;
        end
        if (i_cmd.div_start) begin
            r_neg <= w_num[asvdm_pkg::NUM_W-1];
        end
        if (i_cmd.div_capture) begin
            unique case (r_op)
                3'd0:    r_lo[0] <= w_bound;
                3'd1:    r_hi[0] <= w_bound;
                3'd2:    r_lo[1] <= w_bound;
                3'd3:    r_hi[1] <= w_bound;
                3'd4:    r_lo[2] <= w_bound;
                default: r_hi[2] <= w_bound;
            endcase
            r_op <= r_op + 1'b1;
        end
        if (i_cmd.bounds_init) begin
            r_idx[0] <= r_lo[0];
            r_idx[1] <= r_lo[1];
            r_idx[2] <= r_lo[2];
        end
        if (i_cmd.sq_en) begin
            if (i_cmd.step < 3'd3) begin
                r_off <= w_off;
            end
            if (i_cmd.step >= 3'd1 && i_cmd.step <= 3'd3) begin
                r_prod <= asvdm_pkg::SQ_W'(w_sqr);
            end
            if (i_cmd.step == 3'd0) begin
                r_acc <= '0;
            end else if (i_cmd.step >= 3'd2) begin
                r_acc <= r_acc + 48'(r_prod);
            end
        end
        if (i_cmd.sqrt_init) begin
            r_sv   <= r_acc[asvdm_pkg::RR_W-1:0];
            r_root <= '0;
            r_bit  <= 26'(1) << asvdm_pkg::SQRT_TOP;
        end
        if (i_cmd.sqrt_step) begin
            if ({1'b0, r_sv} >= w_trial) begin
                r_sv   <= r_sv - w_trial[asvdm_pkg::RR_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.merge && r_count != '1) begin
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.advance) begin
            if (w_last_k) begin
                r_idx[2] <= r_lo[2];
                if (w_last_j) begin
                    r_idx[1] <= r_lo[1];
                    r_idx[0] <= r_idx[0] + 1'b1;
                end else begin
                    r_idx[1] <= r_idx[1] + 1'b1;
                end
            end else begin
                r_idx[2] <= r_idx[2] + 1'b1;
            end
        end
    end

    // stores
    logic [AW-1:0] w_walk_addr;
    logic [AW-1:0] w_read_addr;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic          w_we;
    logic          w_rd_err;
    logic [31:0]   w_wa32;
    logic [31:0]   w_ra32;

    assign w_wa32      = vox_addr(32'(r_idx[0]), 32'(r_idx[1]), 32'(r_idx[2]));
    assign w_ra32      = vox_addr(32'(r_vi), 32'(r_vj), 32'(r_vk));
    assign w_walk_addr = w_wa32[AW-1:0];
    assign w_read_addr = w_ra32[AW-1:0];
    assign w_raddr     = r_cmd_read ? w_read_addr : w_walk_addr;
    assign w_waddr     = i_cmd.clr_en ? r_clr_addr : w_walk_addr;
    assign w_we        = i_cmd.clr_en | i_cmd.merge;
    assign w_rd_err    = (32'(r_vi) >= 32'(w_dim[0])) || (32'(r_vj) >= 32'(w_dim[1])) ||
                         (32'(r_vk) >= 32'(w_dim[2]));

    asvdm_ram #(.WIDTH(asvdm_pkg::DIST_W), .DEPTH(DEPTH)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.clr_en ? '0 : w_nv),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_dist)
    );

    asvdm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_solv_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.clr_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_solv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_cmd_read) begin
                o_voxels_inside  <= '0;
                o_index_error    <= w_rd_err;
                o_distance_value <= w_rd_err ? '0 : w_rd_dist;
                o_solvent_flag   <= w_rd_err ? 1'b0 : w_rd_solv;
            end else begin
                o_voxels_inside  <= r_count;
                o_index_error    <= 1'b0;
                o_distance_value <= '0;
                o_solvent_flag   <= 1'b0;
            end
        end
    end

    assign o_stat.cmd_read   = r_cmd_read;
    assign o_stat.div_busy   = w_busy;
    assign o_stat.op_last    = r_op == 3'd5;
    assign o_stat.empty      = (r_lo[0] >= r_hi[0]) || (r_lo[1] >= r_hi[1]) ||
                               (r_lo[2] >= r_hi[2]);
    assign o_stat.in_sphere  = r_acc < 48'(r_rr);
    assign o_stat.last_voxel = w_last_i & w_last_j & w_last_k;
    assign o_stat.clr_last   = r_clr_addr == AW'(DEPTH - 1);

endmodule

// File: rtl/asvdm_ctrl.sv
// ----------------------------------------------------------------------------
// asvdm_ctrl
// Sequencer: clear pass, bound divisions, voxel walk and result handoff.
// ----------------------------------------------------------------------------
module asvdm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  asvdm_pkg::t_dp_stat i_stat,
    output asvdm_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_PREP, S_DIV_START, S_DIV_WAIT,
        S_BOUNDS, S_SQ, S_CMP, S_SQRT, S_MERGE, S_ADV, S_FIN
    } t_state;

    t_state     r_state;
    logic [2:0] r_step;
    logic [3:0] r_iter;
    logic       w_out_free;

    assign w_out_free = !o_valid || i_ready;
    assign o_ready    = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
            r_iter  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_state <= i_stat.cmd_read ? S_RD_WAIT : S_DIV_START;
                end
                S_RD_WAIT: begin
                    r_state <= S_FIN;
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (!i_stat.div_busy) begin
                        r_state <= i_stat.op_last ? S_BOUNDS : S_DIV_START;
                    end
                end
                S_BOUNDS: begin
                    r_step  <= '0;
                    r_state <= i_stat.empty ? S_FIN : S_SQ;
                end
                S_SQ: begin
                    if (r_step == 3'd4) begin
                        r_state <= S_CMP;
                    end
                    r_step <= r_step + 1'b1;
                end
                S_CMP: begin
                    r_iter  <= '0;
                    r_state <= i_stat.in_sphere ? S_SQRT : S_ADV;
                end
                S_SQRT: begin
                    if (r_iter == 4'(asvdm_pkg::SQRT_STEPS - 1)) begin
                        r_state <= S_MERGE;
                    end
                    r_iter <= r_iter + 1'b1;
                end
                S_MERGE: begin
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    r_step  <= '0;
                    r_state <= i_stat.last_voxel ? S_FIN : S_SQ;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.step        = r_step;
        o_cmd.load        = (r_state == S_IDLE) && i_valid;
        o_cmd.prep        = r_state == S_PREP;
        o_cmd.div_start   = r_state == S_DIV_START;
        o_cmd.div_capture = (r_state == S_DIV_WAIT) && !i_stat.div_busy;
        o_cmd.bounds_init = r_state == S_BOUNDS;
        o_cmd.sq_en       = r_state == S_SQ;
        o_cmd.sqrt_init   = (r_state == S_CMP) && i_stat.in_sphere;
        o_cmd.sqrt_step   = r_state == S_SQRT;
        o_cmd.merge       = r_state == S_MERGE;
        o_cmd.advance     = (r_state == S_ADV) && !i_stat.last_voxel;
        o_cmd.out_load    = (r_state == S_FIN) && w_out_free;
        o_cmd.clr_en      = r_state == S_CLEAR;
    end

endmodule

// File: rtl/atom_sphere_voxel_distance_map_core.sv
// ----------------------------------------------------------------------------
// atom_sphere_voxel_distance_map_core
// Atom sphere voxelizer with distance map and voxel read back.
// ----------------------------------------------------------------------------
// Read item: result after prep, a read wait and the handoff. Place item: six
// bound divisions on one shared divider, plus prep, bounds and handoff, then
// a walk over each voxel of the clamped box, with a bit-serial square root
// for each voxel inside the sphere, plus any wait on the result register.
// One item at a time. Reset: synchronous, active low; afterwards a clearing
// pass writes every store entry, GRID_MAX^3 entries (32768 by default).
module atom_sphere_voxel_distance_map_core #(
    parameter int GRID_MAX = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item in
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_command,
    input  logic [asvdm_pkg::CRD_W-1:0]     i_atom_x,
    input  logic [asvdm_pkg::CRD_W-1:0]     i_atom_y,
    input  logic [asvdm_pkg::CRD_W-1:0]     i_atom_z,
    input  logic [asvdm_pkg::SP_W-1:0]      i_atom_radius,
    input  logic [asvdm_pkg::VIDX_W-1:0]    i_voxel_i,
    input  logic [asvdm_pkg::VIDX_W-1:0]    i_voxel_j,
    input  logic [asvdm_pkg::VIDX_W-1:0]    i_voxel_k,
    // result out
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [asvdm_pkg::CNT_W-1:0]     o_voxels_inside,
    output logic [asvdm_pkg::DIST_W-1:0]    o_distance_value,
    output logic                            o_solvent_flag,
    output logic                            o_index_error,
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [asvdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [asvdm_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    asvdm_pkg::t_dp_cmd  w_cmd;
    asvdm_pkg::t_dp_stat w_stat;

    // registers are to change only while idle (the user's rule; not enforced here), so writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the handshakes and steps the datapath
    asvdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath: bounds, squared distance, root, merge, voxel stores
    asvdm_dp #(.GRID_MAX(GRID_MAX)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_atom_x         (i_atom_x),
        .i_atom_y         (i_atom_y),
        .i_atom_z         (i_atom_z),
        .i_atom_radius    (i_atom_radius),
        .i_voxel_i        (i_voxel_i),
        .i_voxel_j        (i_voxel_j),
        .i_voxel_k        (i_voxel_k),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_voxels_inside  (o_voxels_inside),
        .o_distance_value (o_distance_value),
        .o_solvent_flag   (o_solvent_flag),
        .o_index_error    (o_index_error)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives place and read items into the sphere voxelizer, keeps its own copy
// of the distance and solvent stores, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import asvdm_pkg::*;

    localparam int GMAX        = 32;
    localparam int VOX_N       = GMAX * GMAX * GMAX;
    // a full 31^3 box all inside the sphere must fit under this limit
    localparam int IDLE_LIMIT  = 3000000;
    localparam int SETTLE_CYC  = 20;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]  vox_count;
        logic [DIST_W-1:0] dist_val;
        logic              solvent;
        logic              idx_err;
    } voxel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 in_cmd = 1'b0;
    logic [CRD_W-1:0]     in_x = '0, in_y = '0, in_z = '0;
    logic [SP_W-1:0]      in_rad = '0;
    logic [VIDX_W-1:0]    in_i = '0, in_j = '0, in_k = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CNT_W-1:0]     out_inside;
    logic [DIST_W-1:0]    out_dist;
    logic                 out_solvent;
    logic                 out_idx_err;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    atom_sphere_voxel_distance_map_core #(.GRID_MAX(GMAX)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_command(in_cmd),
        .i_atom_x(in_x), .i_atom_y(in_y), .i_atom_z(in_z), .i_atom_radius(in_rad),
        .i_voxel_i(in_i), .i_voxel_j(in_j), .i_voxel_k(in_k),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_voxels_inside(out_inside), .o_distance_value(out_dist),
        .o_solvent_flag(out_solvent), .o_index_error(out_idx_err),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // shadow of the block's state
    logic [DIST_W-1:0]    dist_map [VOX_N];
    logic                 solvent_map [VOX_N];
    logic [DIMC_W-1:0]    sh_dim [3];
    logic [SP_W-1:0]      sh_spacing, sh_probe;
    logic [CRD_W-1:0]     sh_origin [3];

    voxel_result_t pending_q[$];
    int  err_cnt = 0;
    int  idle_cyc = 0;
    bit  rx_hold = 1'b0;     // long receiver hold-off
    bit  rx_nostall = 1'b0;  // stretch with no receiver stalls

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic int eff_dim(input logic [DIMC_W-1:0] d);
        if (d == 0) return 1;
        if (d > GMAX) return GMAX;
        return int'(d);
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // Predict one item and update the shadow stores.
    function automatic voxel_result_t voxelize_item(input logic cmd,
            input logic [CRD_W-1:0] ax, input logic [CRD_W-1:0] ay,
            input logic [CRD_W-1:0] az, input logic [SP_W-1:0] rad,
            input logic [VIDX_W-1:0] vi, input logic [VIDX_W-1:0] vj,
            input logic [VIDX_W-1:0] vk);
        voxel_result_t res;
        longint dm[3], d[3], lo[3], hi[3];
        longint s, pr, reach, thr, di, dj, dk, sq, val, old, nv, cnt, t;
        int a;
        res = '0;
        for (int n = 0; n < 3; n++) dm[n] = eff_dim(sh_dim[n]);
        if (cmd == CMD_READ) begin
            if (vi >= dm[0] || vj >= dm[1] || vk >= dm[2]) begin
                res.idx_err = 1'b1;
            end else begin
                a = (int'(vi) * GMAX + int'(vj)) * GMAX + int'(vk);
                res.dist_val = dist_map[a];
                res.solvent = solvent_map[a];
            end
            return res;
        end
        s = (sh_spacing == 0) ? 1 : longint'(sh_spacing);
        pr = longint'(sh_probe);
        reach = longint'(rad) + pr;
        thr = 25600 - pr;
        d[0] = longint'($signed(ax)) - longint'($signed(sh_origin[0]));
        d[1] = longint'($signed(ay)) - longint'($signed(sh_origin[1]));
        d[2] = longint'($signed(az)) - longint'($signed(sh_origin[2]));
        for (int n = 0; n < 3; n++) begin
            // SV division truncates toward zero like the spec
            t = (d[n] - reach) / s - 1;
            lo[n] = (t < 0) ? 0 : ((t > dm[n] - 1) ? dm[n] - 1 : t);
            t = (d[n] + reach) / s + 1;
            hi[n] = (t < 0) ? 0 : ((t > dm[n] - 1) ? dm[n] - 1 : t);
        end
        cnt = 0;
        for (longint i = lo[0]; i < hi[0]; i++) begin
            di = i * s - d[0];
            for (longint j = lo[1]; j < hi[1]; j++) begin
                dj = j * s - d[1];
                for (longint k = lo[2]; k < hi[2]; k++) begin
                    dk = k * s - d[2];
                    sq = di * di + dj * dj + dk * dk;
                    if (sq < reach * reach) begin
                        a = int'((i * GMAX + j) * GMAX + k);
                        val = 25600 - reach + floor_sqrt(sq);
                        old = longint'(dist_map[a]);
                        nv = old;
                        solvent_map[a] = 1'b0;
                        if (old * 10 > 256) begin
                            if (old < thr) begin
                                if (val < old) nv = val;
                            end else if (val < thr) begin
                                nv = val;
                            end else begin
                                nv = 51200;
                            end
                        end else begin
                            nv = val;
                        end
                        if (nv < 0) nv = 0;
                        if (nv > 65535) nv = 65535;
                        dist_map[a] = nv[DIST_W-1:0];
                        if (cnt < 65535) cnt++;
                    end
                end
            end
        end
        res.vox_count = cnt[CNT_W-1:0];
        return res;
    endfunction

    // Send one item; predicts at acceptance.
    task automatic send_item(input logic cmd, input logic [CRD_W-1:0] ax,
            input logic [CRD_W-1:0] ay, input logic [CRD_W-1:0] az,
            input logic [SP_W-1:0] rad, input logic [VIDX_W-1:0] vi,
            input logic [VIDX_W-1:0] vj, input logic [VIDX_W-1:0] vk);
        in_valid <= 1'b1;
        in_cmd <= cmd;
        in_x <= ax; in_y <= ay; in_z <= az; in_rad <= rad;
        in_i <= vi; in_j <= vj; in_k <= vk;
        do @(posedge clk); while (!in_ready);
        pending_q.push_back(voxelize_item(cmd, ax, ay, az, rad, vi, vj, vk));
    endtask

    // Drop valid for a random gap after a burst.
    task automatic sender_gap(input int max_gap);
        int g;
        g = $urandom_range(0, max_gap);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic place_atom(input int ax, input int ay, input int az, input int rad);
        send_item(CMD_PLACE, ax[CRD_W-1:0], ay[CRD_W-1:0], az[CRD_W-1:0],
                  rad[SP_W-1:0], VIDX_W'($urandom), VIDX_W'($urandom),
                  VIDX_W'($urandom));
    endtask

    task automatic read_voxel(input int vi, input int vj, input int vk);
        send_item(CMD_READ, CRD_W'($urandom), CRD_W'($urandom), CRD_W'($urandom),
                  SP_W'($urandom), vi[VIDX_W-1:0], vj[VIDX_W-1:0], vk[VIDX_W-1:0]);
    endtask

    // Wait until every expected result is back, then settle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DAT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DIM_X:    sh_dim[0] = val[DIMC_W-1:0];
            CFG_DIM_Y:    sh_dim[1] = val[DIMC_W-1:0];
            CFG_DIM_Z:    sh_dim[2] = val[DIMC_W-1:0];
            CFG_SPACING:  sh_spacing = val[SP_W-1:0];
            CFG_PROBE:    sh_probe = val[SP_W-1:0];
            CFG_ORIGIN_X: sh_origin[0] = val[CRD_W-1:0];
            CFG_ORIGIN_Y: sh_origin[1] = val[CRD_W-1:0];
            CFG_ORIGIN_Z: sh_origin[2] = val[CRD_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input int dx, input int dy, input int dz, input int sp,
                            input int pr, input int ox, input int oy, input int oz);
        write_reg(CFG_DIM_X, dx);
        write_reg(CFG_DIM_Y, dy);
        write_reg(CFG_DIM_Z, dz);
        write_reg(CFG_SPACING, sp);
        write_reg(CFG_PROBE, pr);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
    endtask

    // Directed: reset contents, small and big spheres, merges, read bounds.
    task automatic test_directed;
        read_voxel(0, 0, 0);               // cleared store
        read_voxel(31, 31, 31);
        place_atom(512, 512, 512, 128);    // default grid
        read_voxel(4, 4, 4);
        place_atom(512, 512, 512, 200);    // merge over a set value
        read_voxel(4, 4, 4);
        place_atom(600, 560, 500, 0);      // reach is probe only
        place_atom(-524288, -524288, -524288, 4095);  // fully outside, low side
        place_atom(524287, 524287, 524287, 4095);     // clamped high side
        place_atom(3968, 3968, 3968, 300); // box clamped short of the last voxel of each axis
        read_voxel(31, 31, 30);            // last index of an axis is never written
        read_voxel(30, 30, 30);
        drain();
        set_grid(4, 63, 0, 0, 0, -524288, 524287, 0);  // extent clamps, zero spacing
        read_voxel(4, 0, 0);               // out of range on first axis
        read_voxel(3, 31, 0);
        read_voxel(0, 0, 1);               // z extent 0 behaves as 1
        place_atom(-524288, 524287, 0, 4095);
        read_voxel(1, 1, 0);
        drain();
        write_reg(4'd9, 123);              // unused register index is ignored
        write_reg(4'd15, 456);
        set_grid(8, 8, 8, 4095, 4095, 0, 0, 0);       // huge voxels, max probe
        place_atom(4095, 4095, 4095, 4095);
        read_voxel(1, 1, 1);
        read_voxel(7, 7, 7);
        drain();
    endtask

    // Random places and reads over a few grid settings.
    task automatic test_random(input int n_items);
        int burst;
        int sp;
        int sx;
        burst = 0;
        for (int n = 0; n < n_items; n++) begin
            if (n % 35 == 0) begin
                drain();
                sp = (n % 70 == 0) ? $urandom_range(96, 400) : $urandom_range(1, 4095);
                set_grid($urandom_range(1, 32), $urandom_range(1, 32),
                         $urandom_range(0, 63), sp, $urandom_range(0, 4095),
                         $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                         $urandom_range(0, 2000) - 1000);
            end
            if (burst == 0) begin
                sender_gap(6);
                burst = $urandom_range(1, 8);
            end
            burst--;
            if ($urandom_range(0, 99) < 45) begin
                read_voxel($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31));
            end else if ($urandom_range(0, 9) == 0) begin
                // wild atom: any coordinate bit pattern, most land off grid
                place_atom($urandom, $urandom, $urandom, $urandom_range(0, 4095));
            end else begin
                // keep boxes small so runs stay short
                sx = (sp > 0) ? sp : 1;
                place_atom($urandom_range(0, 32 * sx), $urandom_range(0, 32 * sx),
                           $urandom_range(0, 32 * sx), $urandom_range(0, 400));
            end
        end
        drain();
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure;
        rx_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                for (int n = 0; n < 6; n++) read_voxel(n, n, n);
                place_atom(1000, 1000, 1000, 100);
            end
        join
        rx_nostall = 1'b1;
        for (int n = 0; n < 8; n++) read_voxel($urandom_range(0, 31), 2, 3);
        drain();
        rx_nostall = 1'b0;
    endtask

    // Receiver stall pattern.
    always @(posedge clk) begin
        if (rx_hold) out_ready <= 1'b0;
        else if (rx_nostall) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Result checker.
    always @(posedge clk) begin
        voxel_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_q.pop_front();
                if (out_inside !== want.vox_count)
                    report_mismatch("voxels_inside", int'(out_inside),
                                    int'(want.vox_count));
                if (out_dist !== want.dist_val)
                    report_mismatch("distance_value", int'(out_dist), int'(want.dist_val));
                if (out_solvent !== want.solvent)
                    report_mismatch("solvent_flag", int'(out_solvent), int'(want.solvent));
                if (out_idx_err !== want.idx_err)
                    report_mismatch("index_error", int'(out_idx_err), int'(want.idx_err));
            end
        end
    end

    // Watchdog: cycles without any accepted item, result or register write.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc > IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        for (int a = 0; a < VOX_N; a++) begin
            dist_map[a] = '0;
            solvent_map[a] = 1'b1;
        end
        for (int n = 0; n < 3; n++) begin
            sh_dim[n] = DIM_RST;
            sh_origin[n] = '0;
        end
        sh_spacing = SPACING_RST;
        sh_probe = PROBE_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(105);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/asvdm_pkg.sv
rtl/asvdm_ram.sv
rtl/asvdm_div.sv
rtl/asvdm_dp.sv
rtl/asvdm_ctrl.sv
rtl/atom_sphere_voxel_distance_map_core.sv
tb/tb_top.sv
